/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frustum test core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/fct_pkg.sv */
// ---------------------------------------------------------------------------
// fct_pkg
// Types and constants shared by the frustum test core.
// ---------------------------------------------------------------------------
package fct_pkg;

	localparam int PLANE_REGS = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int COORD_W    = 16;
	localparam int PROD_W     = 32;
	localparam int SUM_W      = 34;
	localparam int Q_SHIFT    = 14;

	localparam logic ACT_POINT = 1'b0;
	localparam logic ACT_BOX   = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] a;
		logic signed [COORD_W-1:0] b;
		logic signed [COORD_W-1:0] c;
		logic signed [COORD_W-1:0] d;
	} plane_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} adv_t;

endpackage

/* design/fct_plane_regs.sv */
// ---------------------------------------------------------------------------
// fct_plane_regs
// Configuration storage for the clipping planes, cleared at reset.
// ---------------------------------------------------------------------------
module fct_plane_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [fct_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fct_pkg::CFG_DATA_W-1:0]       cfg_data,
	output fct_pkg::plane_t [fct_pkg::PLANE_REGS-1:0] planes
);

	fct_pkg::plane_t [fct_pkg::PLANE_REGS-1:0] plane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_write && (cfg_index < fct_pkg::CFG_IDX_W'(fct_pkg::PLANE_REGS))) begin
			plane_q[cfg_index] <= fct_pkg::plane_t'(cfg_data);
		end
	end

	assign planes = plane_q;

endmodule

/* design/fct_plane_dot.sv */
// ---------------------------------------------------------------------------
// fct_plane_dot
// Two pipeline stages for one plane: products of the chosen corner, then the
// signed sum and the positive-side decision.
// ---------------------------------------------------------------------------
module fct_plane_dot (
	input  logic                    clk,
	input  fct_pkg::adv_t           adv,
	input  fct_pkg::plane_t         plane,
	input  logic                    box_s1,
	input  fct_pkg::coord_t [2:0]   lo_s1,
	input  fct_pkg::coord_t [2:0]   hi_s1,
	output logic                    pass_s3
);

	logic signed [fct_pkg::COORD_W-1:0] coef [3];
	fct_pkg::coord_t                    sel [3];
	logic signed [fct_pkg::PROD_W-1:0]  prod_s2 [3];
	logic signed [fct_pkg::COORD_W-1:0] d_s2;
	logic signed [fct_pkg::SUM_W-1:0]   sum;

	// A box reaches its largest sum at the corner that takes, on each axis,
	// the larger bound for a non-negative coefficient and the smaller otherwise.
	always_comb begin
		coef[0] = plane.a;
		coef[1] = plane.b;
		coef[2] = plane.c;
		for (int k = 0; k < 3; k++) begin
			sel[k] = (box_s1 && !coef[k][fct_pkg::COORD_W-1]) ? hi_s1[k] : lo_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			for (int k = 0; k < 3; k++) begin
				prod_s2[k] <= coef[k] * sel[k];
			end
			d_s2 <= plane.d;
		end
	end

	always_comb begin
		sum = {{(fct_pkg::SUM_W-fct_pkg::PROD_W){prod_s2[0][fct_pkg::PROD_W-1]}}, prod_s2[0]}
		    + {{(fct_pkg::SUM_W-fct_pkg::PROD_W){prod_s2[1][fct_pkg::PROD_W-1]}}, prod_s2[1]}
		    + {{(fct_pkg::SUM_W-fct_pkg::PROD_W){prod_s2[2][fct_pkg::PROD_W-1]}}, prod_s2[2]}
		    + {{(fct_pkg::SUM_W-fct_pkg::COORD_W-fct_pkg::Q_SHIFT){d_s2[fct_pkg::COORD_W-1]}},
		       d_s2, {fct_pkg::Q_SHIFT{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			pass_s3 <= !sum[fct_pkg::SUM_W-1] && (sum != '0);
		end
	end

endmodule

/* design/frustum_cull_test_core.sv */
// ---------------------------------------------------------------------------
// frustum_cull_test_core
// Point and box visibility test against the configured frustum planes.
// ---------------------------------------------------------------------------
// A request on req_valid/req_ready carries a point (action 0, the min
// coordinates) or an axis-aligned box (action 1). One result, visible,
// leaves on res_valid/res_ready for every request, in request order.
// Planes are to be written on the cfg port only while no request is in
// flight; the block does not enforce this. An index past the sixth
// register is ignored. The pipeline has four register stages: corner
// bounds, products, sum and sign per plane, then the output register,
// which drives res_valid. A new request can be taken in every cycle while
// the receiver does not stall. Each tested plane has its own multipliers.
// When the receiver stalls, each stage holds its item and empty stages
// still fill, so up to four requests wait inside before req_ready drops.
// Reset clears all valid bits and all plane registers; with zero planes
// nothing is visible until the planes are written.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frustum_cull_test_core #(
	parameter int PLANE_COUNT = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [fct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fct_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           action,
	input  logic signed [15:0]             x_min,
	input  logic signed [15:0]             y_min,
	input  logic signed [15:0]             z_min,
	input  logic signed [15:0]             x_max,
	input  logic signed [15:0]             y_max,
	input  logic signed [15:0]             z_max,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic                           visible
);

	localparam int TESTED = (PLANE_COUNT < fct_pkg::PLANE_REGS) ? PLANE_COUNT
	                                                            : fct_pkg::PLANE_REGS;

	fct_pkg::plane_t [fct_pkg::PLANE_REGS-1:0] planes;
	fct_pkg::coord_t [2:0] in_lo;
	fct_pkg::coord_t [2:0] in_hi;
	fct_pkg::coord_t [2:0] lo_s1;
	fct_pkg::coord_t [2:0] hi_s1;
	logic              is_box;
	logic              box_s1;
	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic              v_s4;
	logic              rdy_s1;
	logic              rdy_s2;
	logic              rdy_s3;
	logic              rdy_s4;
	logic [TESTED-1:0] pass_s3;
	logic              visible_s4;
	fct_pkg::adv_t     adv;

	fct_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	assign rdy_s4    = !v_s4 || res_ready;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req_ready = rdy_s1;

	assign adv.ld_s2 = v_s1 && rdy_s2;
	assign adv.ld_s3 = v_s2 && rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= req_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign is_box = (action == fct_pkg::ACT_BOX);

	// For a point the low bound is the point itself; for a box the bounds
	// are ordered so swapped corners give the same eight corners.
	always_comb begin
		in_lo[0] = (is_box && (x_max < x_min)) ? x_max : x_min;
		in_lo[1] = (is_box && (y_max < y_min)) ? y_max : y_min;
		in_lo[2] = (is_box && (z_max < z_min)) ? z_max : z_min;
		in_hi[0] = (x_max < x_min) ? x_min : x_max;
		in_hi[1] = (y_max < y_min) ? y_min : y_max;
		in_hi[2] = (z_max < z_min) ? z_min : z_max;
	end

	always_ff @(posedge clk) begin
		if (req_valid && rdy_s1) begin
			box_s1 <= is_box;
			lo_s1  <= in_lo;
			hi_s1  <= in_hi;
		end
	end

	for (genvar p = 0; p < TESTED; p++) begin : g_plane
		fct_plane_dot u_dot (
			.clk     (clk),
			.adv     (adv),
			.plane   (planes[p]),
			.box_s1  (box_s1),
			.lo_s1   (lo_s1),
			.hi_s1   (hi_s1),
			.pass_s3 (pass_s3[p])
		);
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			visible_s4 <= &pass_s3;
		end
	end

	assign res_valid = v_s4;
	assign visible   = visible_s4;

	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, req_valid && req_ready, v_s1)
	`ASSERT_NEXT(a_s1_holds, clk, arst_n, v_s1 && !rdy_s2, v_s1 && $stable(lo_s1) && $stable(hi_s1))
	`ASSERT_NEXT(a_s3_holds, clk, arst_n, v_s3 && !rdy_s4, v_s3 && $stable(pass_s3))
	`ASSERT_SAME(a_ready_when_empty, clk, arst_n, !v_s1 && !v_s2 && !v_s3 && !v_s4, req_ready)

endmodule

/* bench/frustum_cull_test_core_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frustum_cull_test_core_tb
// Checks point and box visibility results against an internal predictor.
// ---------------------------------------------------------------------------
// Plane sets range from the all-zero reset state through exact and jittered
// axis-aligned frustums to register extremes and fully random planes.
// Requests are points and boxes near the frustum walls plus full-range
// noise. Both handshake sides stall at random. Every result is compared
// in order with the value predicted from the planes that were written.
// ---------------------------------------------------------------------------
module frustum_cull_test_core_tb;

	localparam int TESTED_PLANES = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int PHASE_ITEMS   = 150;

	localparam int STYLE_EXACT   = 0;
	localparam int STYLE_FRUSTUM = 1;
	localparam int STYLE_RANDOM  = 2;
	localparam int STYLE_EXTREME = 3;

	typedef enum logic [fct_pkg::CFG_IDX_W-1:0] {
		REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP, REG_FAR, REG_NEAR, REG_SPARE6, REG_SPARE7
	} plane_reg_e;

	class visibility_scoreboard;
		fct_pkg::plane_t planes[fct_pkg::PLANE_REGS];
		bit     visible_q[$];
		int     requests;
		int     checked;
		int     mismatches;

		function new();
			foreach (planes[i])
				planes[i] = '0;
		endfunction

		function void set_plane(int idx, logic [fct_pkg::CFG_DATA_W-1:0] value);
			if (idx < fct_pkg::PLANE_REGS)
				planes[idx] = value;
		endfunction

		function automatic bit on_positive_side(fct_pkg::plane_t p, fct_pkg::coord_t x,
				fct_pkg::coord_t y, fct_pkg::coord_t z);
			longint sum;
			sum = longint'($signed(p.a)) * longint'($signed(x))
				+ longint'($signed(p.b)) * longint'($signed(y))
				+ longint'($signed(p.c)) * longint'($signed(z))
				+ longint'($signed(p.d)) * (longint'(1) <<< fct_pkg::Q_SHIFT);
			return sum > 0;
		endfunction

		function automatic bit predict_visible(logic box, fct_pkg::coord_t lo[3],
				fct_pkg::coord_t hi[3]);
			bit seen;
			bit pass;
			seen = 1'b1;
			for (int i = 0; i < TESTED_PLANES && i < fct_pkg::PLANE_REGS; i++) begin
				if (!box) begin
					pass = on_positive_side(planes[i], lo[0], lo[1], lo[2]);
				end else begin
					pass = 1'b0;
					for (int k = 0; k < 8; k++) begin
						if (on_positive_side(planes[i], k[0] ? hi[0] : lo[0],
								k[1] ? hi[1] : lo[1], k[2] ? hi[2] : lo[2]))
							pass = 1'b1;
					end
				end
				if (!pass)
					seen = 1'b0;
			end
			return seen;
		endfunction

		function void note_request(logic box, fct_pkg::coord_t x0, fct_pkg::coord_t y0,
				fct_pkg::coord_t z0, fct_pkg::coord_t x1, fct_pkg::coord_t y1,
				fct_pkg::coord_t z1);
			fct_pkg::coord_t lo[3];
			fct_pkg::coord_t hi[3];
			lo = '{x0, y0, z0};
			hi = '{x1, y1, z1};
			visible_q.push_back(predict_visible(box, lo, hi));
			requests++;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic vis);
			bit want;
			if (visible_q.size() == 0) begin
				report_mismatch($sformatf("result visible=%b with no request waiting", vis));
			end else begin
				want = visible_q.pop_front();
				checked++;
				if (vis !== want)
					report_mismatch($sformatf("result %0d: visible=%b, expected %b",
						checked, vis, want));
			end
		endtask
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_write;
	logic [fct_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [fct_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           req_valid;
	logic                           req_ready;
	logic                           action;
	fct_pkg::coord_t                x_min;
	fct_pkg::coord_t                y_min;
	fct_pkg::coord_t                z_min;
	fct_pkg::coord_t                x_max;
	fct_pkg::coord_t                y_max;
	fct_pkg::coord_t                z_max;
	logic                           res_valid;
	logic                           res_ready;
	logic                           visible;

	visibility_scoreboard           sb;
	logic [fct_pkg::CFG_DATA_W-1:0] phase_planes[fct_pkg::PLANE_REGS];
	int                             box_lo[3];
	int                             box_hi[3];
	fct_pkg::coord_t                extremes[5] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1,
	                                                16'sd32767};
	bit                             no_stall;
	int                             cycles;
	int                             settings;

	frustum_cull_test_core #(
		.PLANE_COUNT(TESTED_PLANES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action),
		.x_min     (x_min),
		.y_min     (y_min),
		.z_min     (z_min),
		.x_max     (x_max),
		.y_max     (y_max),
		.z_max     (z_max),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.visible   (visible)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_ready <= no_stall || ($urandom_range(0, 99) >= 7);
	end

	// Handshake signals change only at rising edges, so the falling edge sees
	// exactly what the next rising edge will accept.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(action, x_min, y_min, z_min, x_max, y_max, z_max);
			if (res_valid && res_ready)
				sb.check_result(visible);
		end
	end

	task automatic send_request(logic act, fct_pkg::coord_t x0, fct_pkg::coord_t y0,
			fct_pkg::coord_t z0, fct_pkg::coord_t x1, fct_pkg::coord_t y1,
			fct_pkg::coord_t z1);
		bit taken;
		req_valid <= 1'b1;
		action    <= act;
		x_min     <= x0;
		y_min     <= y0;
		z_min     <= z0;
		x_max     <= x1;
		y_max     <= y1;
		z_max     <= z1;
		do begin
			@(negedge clk);
			taken = req_valid && req_ready;
			@(posedge clk);
		end while (!taken);
		if (!no_stall && $urandom_range(0, 99) < 7) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (sb.visible_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The two spare indexes get junk on every load; the block must ignore it.
	task automatic load_frustum();
		for (int i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= plane_reg_e'(i);
			cfg_data  <= (i < fct_pkg::PLANE_REGS) ? phase_planes[i] : {$urandom, $urandom};
			sb.set_plane(i, phase_planes[i % fct_pkg::PLANE_REGS]);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		settings++;
	endtask

	task automatic pick_frustum(int style);
		fct_pkg::coord_t coef[3];
		fct_pkg::coord_t plane_d;
		int              sgn;
		int              jit;
		for (int i = 0; i < fct_pkg::PLANE_REGS; i++) begin
			case (style)
				STYLE_RANDOM: begin
					phase_planes[i] = {$urandom, $urandom};
				end
				STYLE_EXTREME: begin
					phase_planes[i] = {extremes[$urandom_range(0, 4)], extremes[$urandom_range(0, 4)],
						extremes[$urandom_range(0, 4)], extremes[$urandom_range(0, 4)]};
				end
				default: begin
					sgn = (i % 2 == 0) ? 1 : -1;
					jit = (style == STYLE_EXACT) ? 0 : 1;
					for (int k = 0; k < 3; k++)
						coef[k] = fct_pkg::coord_t'(jit * (int'($urandom_range(0, 1200)) - 600));
					coef[i / 2] = fct_pkg::coord_t'(sgn * (16384
						+ jit * (int'($urandom_range(0, 1600)) - 800)));
					plane_d = fct_pkg::coord_t'((sgn > 0) ? -box_lo[i / 2] : box_hi[i / 2]);
					phase_planes[i] = {coef[0], coef[1], coef[2], plane_d};
				end
			endcase
		end
	endtask

	function automatic fct_pkg::coord_t near_coord(int k);
		return fct_pkg::coord_t'(box_lo[k] - 400
			+ int'($urandom_range(0, box_hi[k] - box_lo[k] + 800)));
	endfunction

	task automatic run_random_phase(int count);
		fct_pkg::coord_t lo[3];
		fct_pkg::coord_t hi[3];
		int              pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			for (int k = 0; k < 3; k++) begin
				lo[k] = near_coord(k);
				hi[k] = fct_pkg::coord_t'(int'(lo[k]) + int'($urandom_range(0, 600)) - 100);
			end
			if (pick < 15)
				send_request(logic'($urandom_range(0, 1)), fct_pkg::coord_t'($urandom),
					fct_pkg::coord_t'($urandom), fct_pkg::coord_t'($urandom),
					fct_pkg::coord_t'($urandom), fct_pkg::coord_t'($urandom),
					fct_pkg::coord_t'($urandom));
			else if (pick < 55)
				send_request(fct_pkg::ACT_POINT, lo[0], lo[1], lo[2],
					fct_pkg::coord_t'($urandom), fct_pkg::coord_t'($urandom),
					fct_pkg::coord_t'($urandom));
			else
				send_request(fct_pkg::ACT_BOX, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
		end
	endtask

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		req_valid = 1'b0;
		action    = fct_pkg::ACT_POINT;
		x_min     = '0;
		y_min     = '0;
		z_min     = '0;
		x_max     = '0;
		y_max     = '0;
		z_max     = '0;
		no_stall  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Planes still cleared by reset: every sum is zero, nothing is visible.
		send_request(fct_pkg::ACT_POINT, 0, 0, 0, 0, 0, 0);
		send_request(fct_pkg::ACT_BOX, -32768, -32768, -32768, 32767, 32767, 32767);
		wait_idle();

		box_lo = '{-100, -200, -50};
		box_hi = '{100, 200, 300};
		pick_frustum(STYLE_EXACT);
		load_frustum();
		send_request(fct_pkg::ACT_POINT, 0, 0, 0, -32768, -32768, -32768);
		send_request(fct_pkg::ACT_POINT, -100, 0, 0, 0, 0, 0);
		send_request(fct_pkg::ACT_POINT, -99, 0, 0, 0, 0, 0);
		send_request(fct_pkg::ACT_POINT, 100, 0, 0, 0, 0, 0);
		send_request(fct_pkg::ACT_POINT, 0, 0, 300, 32767, 32767, 32767);
		send_request(fct_pkg::ACT_BOX, 150, 250, 350, -150, -250, -150);
		send_request(fct_pkg::ACT_BOX, -32768, 0, 0, -101, 10, 10);
		send_request(fct_pkg::ACT_BOX, -32768, 0, 0, -100, 10, 10);
		send_request(fct_pkg::ACT_BOX, -32768, -32768, -32768, 32767, 32767, 32767);
		send_request(fct_pkg::ACT_POINT, 32767, 32767, 32767, 0, 0, 0);
		send_request(fct_pkg::ACT_POINT, -32768, -32768, -32768, 0, 0, 0);
		wait_idle();

		for (int s = 0; s < 3; s++) begin
			for (int i = 0; i < fct_pkg::PLANE_REGS; i++)
				phase_planes[i] = (s == 0) ? {4{16'h7FFF}} : (s == 1) ? {4{16'h8000}} : '1;
			load_frustum();
			send_request(fct_pkg::ACT_POINT, 32767, 32767, 32767, 0, 0, 0);
			send_request(fct_pkg::ACT_POINT, -32768, -32768, -32768, 0, 0, 0);
			send_request(fct_pkg::ACT_POINT, -1, -1, -1, 0, 0, 0);
			send_request(fct_pkg::ACT_BOX, -32768, -32768, -32768, 32767, 32767, 32767);
			wait_idle();
		end

		for (int ph = 0; ph < 8; ph++) begin
			for (int k = 0; k < 3; k++) begin
				box_lo[k] = int'($urandom_range(0, 4000)) - 2000;
				box_hi[k] = box_lo[k] + int'($urandom_range(1, 3000));
			end
			no_stall = (ph == 3);
			pick_frustum((ph == 5) ? STYLE_RANDOM : (ph == 6) ? STYLE_EXTREME : STYLE_FRUSTUM);
			load_frustum();
			run_random_phase(PHASE_ITEMS);
			wait_idle();
		end

		$display("Checked %0d results for %0d point and box requests under %0d plane sets.",
			sb.checked, sb.requests, settings);
		$display("Mismatches found: %0d", sb.mismatches);
		if (sb.mismatches == 0 && sb.visible_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/fct_pkg.sv
design/fct_plane_regs.sv
design/fct_plane_dot.sv
design/frustum_cull_test_core.sv
bench/frustum_cull_test_core_tb.sv
